[rtl/multi_stack_search_remove_macros.svh]
// assertion macros for the multi stack search and remove block
`ifndef MULTI_STACK_SEARCH_REMOVE_MACROS_SVH
`define MULTI_STACK_SEARCH_REMOVE_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define MSR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define MSR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/msr_pkg.sv]
// shared constants, types and helpers of the multi stack search and remove block
package msr_pkg;

	localparam int NUM_STACKS  = 8;
	localparam int STACK_DEPTH = 16;
	localparam int DATA_W      = 32;
	localparam int OP_W        = 2;
	localparam int SEL_W       = 3;

	localparam int STK_W   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam int IDX_W   = $clog2(STACK_DEPTH);
	localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
	localparam int ENTRIES = NUM_STACKS * STACK_DEPTH;
	localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// words held inside the block at most: command queue plus one in the back end
	localparam int OUT_MAX = QDEPTH + 1;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_SEARCH = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CMD_PUSH,
		CMD_POP,
		CMD_SEARCH,
		CMD_NONE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [STK_W-1:0]   stk;
		logic [DATA_W-1:0]  value;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_LOAD,
		ST_SCAN,
		ST_CMP,
		ST_SHFT_RD,
		ST_SHFT_WR
	} state_t;

	function automatic logic [ADDR_W-1:0] entry_addr(input logic [STK_W-1:0] stk,
			input logic [IDX_W-1:0] idx);
		return ADDR_W'(stk) * ADDR_W'(STACK_DEPTH) + ADDR_W'(idx);
	endfunction

endpackage

[rtl/msr_in_if.sv]
// request channel: operation, stack select and value
interface msr_in_if import msr_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          operation;
	logic [SEL_W-1:0]         stack_select;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, operation, stack_select, value, input ready);
	modport sink   (input valid, operation, stack_select, value, output ready);
endinterface

[rtl/msr_out_if.sv]
// response channel: ok flag and popped value
interface msr_out_if import msr_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     ok;
	logic signed [DATA_W-1:0] popped_value;

	modport source (output valid, ok, popped_value, input ready);
	modport sink   (input valid, ok, popped_value, output ready);
endinterface

[rtl/msr_ram.sv]
// generic simple dual port ram with registered read
module msr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/msr_front.sv]
// front end: takes request words, classifies them and queues commands
module msr_front import msr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	msr_in_if.sink       req,
	output logic         cmd_valid,
	output cmd_t         cmd,
	input  logic         cmd_take
);

	cmd_t              qmem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] q_cnt_q;
	logic              enq;
	logic              sel_ok;
	cmd_t              cls;

	assign req.ready = (q_cnt_q < QCNT_W'(QDEPTH));
	assign enq       = req.valid && req.ready;
	assign sel_ok    = (32'(req.stack_select) < 32'(NUM_STACKS));

	always_comb begin
		cls.value = req.value;
		cls.stk   = '0;
		cls.kind  = CMD_NONE;
		unique case (req.operation)
			OP_PUSH: begin
				if (sel_ok) begin
					cls.kind = CMD_PUSH;
					cls.stk  = STK_W'(req.stack_select);
				end
			end
			OP_POP: begin
				if (sel_ok) begin
					cls.kind = CMD_POP;
					cls.stk  = STK_W'(req.stack_select);
				end
			end
			OP_SEARCH: begin
				cls.kind = CMD_SEARCH;
			end
			default: begin
				cls.kind = CMD_NONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			qmem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			q_cnt_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (cmd_take) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (enq && !cmd_take) begin
				q_cnt_q <= q_cnt_q + 1'b1;
			end else if (!enq && cmd_take) begin
				q_cnt_q <= q_cnt_q - 1'b1;
			end
		end
	end

	assign cmd_valid = (q_cnt_q != '0);
	assign cmd       = qmem_q[rd_ptr_q];

endmodule

[rtl/msr_back.sv]
// back end: runs push, pop and search against the entry ram and the stack counts
module msr_back import msr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  cmd_t               cmd,
	output logic               cmd_take,
	output logic               ram_we,
	output logic [ADDR_W-1:0]  ram_waddr,
	output logic [DATA_W-1:0]  ram_wdata,
	output logic [ADDR_W-1:0]  ram_raddr,
	input  logic [DATA_W-1:0]  ram_rdata,
	msr_out_if.source          rsp
);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q [NUM_STACKS];
	logic [STK_W-1:0]   stk_q, stk_d;
	logic [CNT_W-1:0]   idx_q, idx_d;
	logic [CNT_W-1:0]   top_q, top_d;
	logic [DATA_W-1:0]  val_q, val_d;
	logic               res_valid_q;
	logic               res_ok_q;
	logic [DATA_W-1:0]  res_data_q;

	logic               slot_free;
	logic               start;
	logic [STK_W-1:0]   rd_stk;
	logic [CNT_W-1:0]   cur_cnt;
	logic               match;
	logic               last_stk;
	logic [CNT_W-1:0]   nxt_idx;

	logic               cnt_we;
	logic [STK_W-1:0]   cnt_wstk;
	logic [CNT_W-1:0]   cnt_wdata;
	logic               res_load;
	logic               res_ok_d;
	logic [DATA_W-1:0]  res_data_d;

	assign slot_free = !res_valid_q || rsp.ready;
	assign start     = (state_q == ST_IDLE) && cmd_valid && slot_free;
	assign cmd_take  = start;
	assign rd_stk    = (state_q == ST_IDLE) ? cmd.stk : stk_q;
	assign cur_cnt   = cnt_q[rd_stk];
	assign match     = (ram_rdata == val_q);
	assign last_stk  = (stk_q == STK_W'(NUM_STACKS - 1));
	assign nxt_idx   = idx_q + 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (cmd.kind)
						CMD_POP:    state_d = (cur_cnt != '0) ? ST_POP : ST_IDLE;
						CMD_SEARCH: state_d = ST_LOAD;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_POP:  state_d = ST_IDLE;
			ST_LOAD: state_d = ST_SCAN;
			ST_SCAN: begin
				if (idx_q == '0) begin
					state_d = last_stk ? ST_IDLE : ST_LOAD;
				end else begin
					state_d = ST_CMP;
				end
			end
			ST_CMP:     state_d = match ? ST_SHFT_RD : ST_SCAN;
			ST_SHFT_RD: state_d = (nxt_idx < top_q) ? ST_SHFT_WR : ST_IDLE;
			ST_SHFT_WR: state_d = ST_SHFT_RD;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs and datapath updates
	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = entry_addr(stk_q, idx_q[IDX_W-1:0]);
		ram_wdata  = ram_rdata;
		ram_raddr  = entry_addr(stk_q, nxt_idx[IDX_W-1:0]);
		cnt_we     = 1'b0;
		cnt_wstk   = stk_q;
		cnt_wdata  = cur_cnt;
		res_load   = 1'b0;
		res_ok_d   = 1'b0;
		res_data_d = '0;
		stk_d      = stk_q;
		idx_d      = idx_q;
		top_d      = top_q;
		val_d      = val_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (cmd.kind)
						CMD_PUSH: begin
							res_load = 1'b1;
							if (cur_cnt < CNT_W'(STACK_DEPTH)) begin
								ram_we    = 1'b1;
								ram_waddr = entry_addr(cmd.stk, cur_cnt[IDX_W-1:0]);
								ram_wdata = cmd.value;
								cnt_we    = 1'b1;
								cnt_wstk  = cmd.stk;
								cnt_wdata = cur_cnt + 1'b1;
								res_ok_d  = 1'b1;
							end
						end
						CMD_POP: begin
							if (cur_cnt != '0) begin
								ram_raddr = entry_addr(cmd.stk, IDX_W'(cur_cnt - 1'b1));
								cnt_we    = 1'b1;
								cnt_wstk  = cmd.stk;
								cnt_wdata = cur_cnt - 1'b1;
								stk_d     = cmd.stk;
							end else begin
								res_load = 1'b1;
							end
						end
						CMD_SEARCH: begin
							stk_d = '0;
							val_d = cmd.value;
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			ST_POP: begin
				res_load   = 1'b1;
				res_ok_d   = 1'b1;
				res_data_d = ram_rdata;
			end
			ST_LOAD: begin
				idx_d = cur_cnt;
				top_d = cur_cnt;
			end
			ST_SCAN: begin
				if (idx_q == '0) begin
					if (last_stk) begin
						res_load = 1'b1;
					end else begin
						stk_d = stk_q + 1'b1;
					end
				end else begin
					// fetch the next entry down from the top
					ram_raddr = entry_addr(stk_q, IDX_W'(idx_q - 1'b1));
					idx_d     = idx_q - 1'b1;
				end
			end
			ST_CMP: begin
			end
			ST_SHFT_RD: begin
				if (!(nxt_idx < top_q)) begin
					cnt_we    = 1'b1;
					cnt_wdata = top_q - 1'b1;
					res_load  = 1'b1;
					res_ok_d  = 1'b1;
				end
			end
			ST_SHFT_WR: begin
				// entry above the hole moves down one place
				ram_we = 1'b1;
				idx_d  = nxt_idx;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			for (int i = 0; i < NUM_STACKS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cnt_we) begin
				cnt_q[cnt_wstk] <= cnt_wdata;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		stk_q <= stk_d;
		idx_q <= idx_d;
		top_q <= top_d;
		val_q <= val_d;
		if (res_load) begin
			res_ok_q   <= res_ok_d;
			res_data_q <= res_data_d;
		end
	end

	assign rsp.valid        = res_valid_q;
	assign rsp.ok           = res_ok_q;
	assign rsp.popped_value = res_data_q;

endmodule

[rtl/multi_stack_search_remove.sv]
// Bounded multi stack with search and remove, top level.
// req carries one word per operation (push, pop, search and remove first match),
// rsp returns one word per request, in order, with ok and the popped value.
// Both channels move a word when valid and ready are high at a rising clk edge.
// Requests go into a two-word command queue; the back end runs one command at a time.
// Push, a failed pop and an unused code are answered from the idle state;
// a successful pop first reads its entry in ST_POP. A search runs ST_LOAD and
// ST_SCAN per stack, ST_SCAN and ST_CMP per compared entry, and ST_SHFT_RD and
// ST_SHFT_WR per shifted entry; it is paced by the single read port of the entry
// ram (one read and one compare per entry).
// Up to three words can sit inside the block; req.ready drops when the queue is full.
// When rsp is stalled the response register holds its word and the back end waits
// before the next command, while the queue keeps taking requests.
// arst_n empties every stack and the queue at once; entry storage is not cleared.
module multi_stack_search_remove import msr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	msr_in_if.sink      req,
	msr_out_if.source   rsp
);

	logic              cmd_valid;
	cmd_t              cmd;
	logic              cmd_take;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	msr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	msr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.rsp       (rsp)
	);

	msr_ram #(
		.WIDTH (DATA_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

[rtl/msr_checker.sv]
// port level checks for the multi stack search and remove block
`include "multi_stack_search_remove_macros.svh"

module msr_checker import msr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  logic              rsp_ok,
	input  logic [DATA_W-1:0] rsp_popped_value
);

	localparam int OCNT_W = $clog2(OUT_MAX + 1);

	logic [OCNT_W-1:0] out_cnt_q;
	logic              in_word;
	logic              out_word;

	assign in_word  = req_valid && req_ready;
	assign out_word = rsp_valid && rsp_ready;

	// words taken in but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else if (in_word && !out_word) begin
			out_cnt_q <= out_cnt_q + 1'b1;
		end else if (!in_word && out_word) begin
			out_cnt_q <= out_cnt_q - 1'b1;
		end
	end

	`MSR_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_ok) && $stable(rsp_popped_value), "stalled response changed")
	`MSR_ASSERT_IMP(a_fail_zero, rsp_valid && !rsp_ok, rsp_popped_value == '0, "failed response with nonzero value")
	`MSR_ASSERT_IMP(a_no_orphan, rsp_valid, out_cnt_q != '0, "response without pending request")
	`MSR_ASSERT_IMP(a_full_stall, out_cnt_q == OCNT_W'(OUT_MAX), !req_ready, "request taken beyond internal capacity")

endmodule

bind multi_stack_search_remove msr_checker u_msr_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_ok           (rsp.ok),
	.rsp_popped_value (rsp.popped_value)
);
